>>> hw/rtl/sstfb_pkg.sv
// ============================================================================
// sstfb_pkg
// Shared types, constants and segment helpers for the time frame builder.
// ============================================================================
package sstfb_pkg;

    typedef enum logic [1:0] {
        ACT_TIME  = 2'd0,
        ACT_ZEROS = 2'd1,
        ACT_BLANK = 2'd2
    } action_t;

    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_ADDR0     = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY   = 8'h8F;
    localparam logic [7:0] CMD_BLANK     = 8'h80;
    localparam logic [7:0] COLON_BIT     = 8'h80;

    localparam logic [19:0] CS_MAX  = 20'd999999;
    localparam logic [6:0]  SEC_MAX = 7'd99;

    // Times at or above this many microseconds saturate the centisecond count.
    localparam logic signed [63:0] SAT_US = 64'sd10000000000;

    // floor(2^40 / 625) and floor(2^27 / 100); each estimate is low by at most one.
    localparam logic [30:0] RECIP_625 = 31'd1759218604;
    localparam int          SHIFT_625 = 40;
    localparam logic [20:0] RECIP_100 = 21'd1342177;
    localparam int          SHIFT_100 = 27;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Byte positions within a seven-byte display frame.
    localparam logic [2:0] POS_CMD  = 3'd0;
    localparam logic [2:0] POS_ADDR = 3'd1;
    localparam logic [2:0] POS_SEG0 = 3'd2;
    localparam logic [2:0] POS_SEG3 = 3'd5;
    localparam logic [2:0] POS_DISP = 3'd6;

    typedef struct packed {
        logic            blank;
        logic [3:0][7:0] segs;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] s;
        unique case (digit)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Upside-down image: a<->d, b<->e, c<->f, g and the colon kept.
    function automatic logic [7:0] rotate_seg(input logic [7:0] s);
        return {s[7:6], s[2:0], s[5:3]};
    endfunction

    // Tens digit of a value below 100, by multiplying with 205/2048.
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'(205);
        return p[14:11];
    endfunction

endpackage

>>> hw/rtl/sstfb_front.sv
// ============================================================================
// sstfb_front
// Accepts requests and turns a time into four segment bytes in a pipeline.
// ============================================================================
module sstfb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic signed [63:0]  time_us,
    input  logic                flip_enable,
    input  sstfb_pkg::qstat_t   q_stat,
    output logic                push,
    output sstfb_pkg::frame_t   push_data
);

    // Stage valid bits: A capture, B divide product, C centiseconds,
    // D second product, E seconds and fraction, F segment bytes.
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic adv;
    logic in_take;

    logic        a_blank_reg, a_zero_reg, a_sat_reg;
    logic [29:0] a_u_reg;
    logic        b_blank_reg, b_zero_reg, b_sat_reg;
    logic [29:0] b_u_reg;
    logic [60:0] b_prod_reg, b_prod_next;
    logic        c_blank_reg;
    logic [19:0] c_cs_reg, c_cs_next;
    logic        d_blank_reg;
    logic [19:0] d_cs_reg;
    logic [40:0] d_prod_reg, d_prod_next;
    logic        e_blank_reg;
    logic [6:0]  e_sec_reg, e_sec_next;
    logic [6:0]  e_frac_reg, e_frac_next;
    sstfb_pkg::frame_t f_frame_reg, f_frame_next;

    logic        known_action;

    // Whole pipeline moves together; it halts only when the queue cannot take F.
    assign adv          = !f_vld_reg || !q_stat.full;
    assign in_ready     = adv;
    assign known_action = (action == sstfb_pkg::ACT_TIME) || (action == sstfb_pkg::ACT_ZEROS)
                          || (action == sstfb_pkg::ACT_BLANK);
    assign in_take      = in_valid && known_action;

    assign push      = f_vld_reg && !q_stat.full;
    assign push_data = f_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_take;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_comb
    begin
        logic [20:0] q;
        logic [30:0] qm;
        logic [30:0] rem;
        logic [20:0] cs_raw;
        logic [13:0] s;
        logic [19:0] sm;
        logic [19:0] rem2;
        logic [13:0] sec_full;
        logic [6:0]  frac;
        logic [3:0]  st, so, ft, fo;
        logic [7:0]  dg0, dg1, dg2, dg3;

        b_prod_next = 61'(a_u_reg) * 61'(sstfb_pkg::RECIP_625);

        q      = b_prod_reg[60:sstfb_pkg::SHIFT_625];
        qm     = 31'(q) * 31'(625);
        rem    = {1'b0, b_u_reg} - qm;
        cs_raw = (rem >= 31'd625) ? q + 21'd1 : q;
        if (b_zero_reg)
            c_cs_next = '0;
        else if (b_sat_reg)
            c_cs_next = sstfb_pkg::CS_MAX;
        else
            c_cs_next = cs_raw[19:0];

        d_prod_next = 41'(c_cs_reg) * 41'(sstfb_pkg::RECIP_100);

        s    = d_prod_reg[40:sstfb_pkg::SHIFT_100];
        sm   = 20'(s) * 20'(100);
        rem2 = d_cs_reg - sm;
        if (rem2 >= 20'd100)
        begin
            sec_full = s + 14'd1;
            frac     = 7'(rem2 - 20'd100);
        end
        else
        begin
            sec_full = s;
            frac     = rem2[6:0];
        end
        e_sec_next  = (sec_full > 14'(sstfb_pkg::SEC_MAX)) ? sstfb_pkg::SEC_MAX : sec_full[6:0];
        e_frac_next = frac;

        st  = sstfb_pkg::tens_of(e_sec_reg);
        so  = 4'(e_sec_reg - 7'(st) * 7'(10));
        ft  = sstfb_pkg::tens_of(e_frac_reg);
        fo  = 4'(e_frac_reg - 7'(ft) * 7'(10));
        dg0 = sstfb_pkg::seg_of(st);
        dg1 = sstfb_pkg::seg_of(so) | sstfb_pkg::COLON_BIT;
        dg2 = sstfb_pkg::seg_of(ft);
        dg3 = sstfb_pkg::seg_of(fo);

        f_frame_next.blank = e_blank_reg;
        if (flip_enable)
        begin
            f_frame_next.segs[0] = sstfb_pkg::rotate_seg(dg3);
            f_frame_next.segs[1] = sstfb_pkg::rotate_seg(dg2);
            f_frame_next.segs[2] = sstfb_pkg::rotate_seg(dg1 & ~sstfb_pkg::COLON_BIT)
                                   | (dg1 & sstfb_pkg::COLON_BIT);
            f_frame_next.segs[3] = sstfb_pkg::rotate_seg(dg0);
        end
        else
        begin
            f_frame_next.segs[0] = dg0;
            f_frame_next.segs[1] = dg1;
            f_frame_next.segs[2] = dg2;
            f_frame_next.segs[3] = dg3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_blank_reg <= (action == sstfb_pkg::ACT_BLANK);
            a_zero_reg  <= (action == sstfb_pkg::ACT_ZEROS) || time_us[63];
            a_sat_reg   <= !time_us[63] && (time_us >= sstfb_pkg::SAT_US);
            a_u_reg     <= time_us[33:4];

            b_blank_reg <= a_blank_reg;
            b_zero_reg  <= a_zero_reg;
            b_sat_reg   <= a_sat_reg;
            b_u_reg     <= a_u_reg;
            b_prod_reg  <= b_prod_next;

            c_blank_reg <= b_blank_reg;
            c_cs_reg    <= c_cs_next;

            d_blank_reg <= c_blank_reg;
            d_cs_reg    <= c_cs_reg;
            d_prod_reg  <= d_prod_next;

            e_blank_reg <= d_blank_reg;
            e_sec_reg   <= e_sec_next;
            e_frac_reg  <= e_frac_next;

            f_frame_reg <= f_frame_next;
        end
    end

endmodule

>>> hw/rtl/sstfb_queue.sv
// ============================================================================
// sstfb_queue
// Short frame queue that decouples the arithmetic front from the byte sequencer.
// ============================================================================
module sstfb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sstfb_pkg::frame_t  push_data,
    input  logic               pop,
    output sstfb_pkg::frame_t  head,
    output sstfb_pkg::qstat_t  q_stat
);

    sstfb_pkg::frame_t mem [sstfb_pkg::Q_DEPTH];

    logic [sstfb_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sstfb_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sstfb_pkg::Q_AW:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == (sstfb_pkg::Q_AW + 1)'(sstfb_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hw/rtl/sstfb_back.sv
// ============================================================================
// sstfb_back
// Byte sequencer: walks the head frame and drives the registered output.
// ============================================================================
module sstfb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sstfb_pkg::frame_t  head,
    input  sstfb_pkg::qstat_t  q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               frame_start,
    output logic               frame_stop,
    output logic               last
);

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       start_reg, start_next;
    logic       stop_reg, stop_next;
    logic       last_reg, last_next;
    logic       load;

    assign load        = !q_stat.empty && (!out_valid_reg || out_ready);
    assign pop         = load && (head.blank || (pos_reg == sstfb_pkg::POS_DISP));
    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign frame_start = start_reg;
    assign frame_stop  = stop_reg;
    assign last        = last_reg;

    always_comb
    begin
        byte_next  = '0;
        start_next = 1'b0;
        stop_next  = 1'b0;
        last_next  = 1'b0;
        if (head.blank)
        begin
            byte_next  = sstfb_pkg::CMD_BLANK;
            start_next = 1'b1;
            stop_next  = 1'b1;
            last_next  = 1'b1;
        end
        else
        begin
            case (pos_reg)
                sstfb_pkg::POS_CMD:
                begin
                    byte_next  = sstfb_pkg::CMD_DATA_AUTO;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                end
                sstfb_pkg::POS_ADDR:
                begin
                    byte_next  = sstfb_pkg::CMD_ADDR0;
                    start_next = 1'b1;
                end
                sstfb_pkg::POS_DISP:
                begin
                    byte_next  = sstfb_pkg::CMD_DISPLAY;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                    last_next  = 1'b1;
                end
                default:
                begin
                    byte_next = head.segs[2'(pos_reg - sstfb_pkg::POS_SEG0)];
                    stop_next = (pos_reg == sstfb_pkg::POS_SEG3);
                end
            endcase
        end

        if (pop)
            pos_next = sstfb_pkg::POS_CMD;
        else if (load)
            pos_next = pos_reg + 3'd1;
        else
            pos_next = pos_reg;

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= sstfb_pkg::POS_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
            last_reg  <= last_next;
        end
    end

endmodule

>>> hw/rtl/seven_segment_time_frame_builder.sv
// ============================================================================
// seven_segment_time_frame_builder
// Builds display driver byte frames for an SS:CC time, zeros or blank.
// ============================================================================
// A request arrives on the in_valid/in_ready channel with action and time_us.
// Show time and show zeros produce seven output transactions: 0x40, 0xC0,
// four segment bytes and 0x8F; blank produces a single 0x80. The last output
// of each request carries last. Action code 3 is dropped without output.
// The cfg channel writes flip_enable; cfg_ready is always high.
// A request passes a six-stage arithmetic pipeline (divide by 10000 and by
// 100 through reciprocal multiplies, digit split, segment lookup), then a
// two-entry frame queue. The output byte sequencer sets the throughput:
// one byte per cycle while the receiver keeps out_ready high, seven bytes
// per shown request and one per blank.
// New requests are taken every cycle until the queue and pipeline fill.
// When the receiver stalls, the output register holds its byte, the queue
// fills and in_ready falls. Reset clears all valid state and flip_enable;
// the block is ready in the first cycle after reset.
// ============================================================================
module seven_segment_time_frame_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [63:0] time_us,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               frame_start,
    output logic               frame_stop,
    output logic               last
);

    logic              flip_enable_reg;
    logic              push;
    logic              pop;
    sstfb_pkg::frame_t push_data;
    sstfb_pkg::frame_t head;
    sstfb_pkg::qstat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flip_enable_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            flip_enable_reg <= cfg_data;
    end

    sstfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .time_us     (time_us),
        .flip_enable (flip_enable_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    sstfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    sstfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .frame_start (frame_start),
        .frame_stop  (frame_stop),
        .last        (last)
    );

    // The closing byte of a request is always a complete one-byte frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_start && frame_stop)
        else $error("last byte is not a complete frame");

    // After the closing byte, the next byte shown opens a new frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid || frame_start)
        else $error("request does not open with a start condition");

    // The queue can never be full and empty at once, and never pops when empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
        else $error("frame queue status inconsistent");

    // A push is never made into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full frame queue");

endmodule

>>> tb/tb_seven_segment_time_frame_builder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_seven_segment_time_frame_builder
// Self-checking bench for the display time frame builder.
// ============================================================================
// Requests are fed from a queue through a bursty valid/ready driver. The
// output side stalls on a rotating pattern and, once, for a long stretch.
// Every accepted request is turned into its expected byte frames using the
// current flip setting. Each output transaction is checked field by field
// against the oldest expected byte. The flip register is only written while
// the block is idle, between phases.
// ============================================================================
module tb_seven_segment_time_frame_builder;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam longint     US_PER_CS    = 10000;
    localparam int         DRAIN_CYCLES = 24;
    localparam int         LONG_HOLD    = 150;
    localparam int         RAND_PHASES  = 8;
    localparam int         PHASE_ITEMS  = 55;
    localparam int         MAX_REPORTS  = 50;
    localparam longint     RUN_LIMIT_NS = 64'd5_000_000;

    // Segment codes of digits 0..9, digit 0 in the low byte.
    localparam logic [79:0] DIGIT_SEGS =
        {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

    typedef struct {
        logic [1:0]         act;
        logic signed [63:0] t;
    } display_request_t;

    typedef struct {
        logic [7:0] b;
        logic       st;
        logic       sp;
        logic       ls;
    } frame_byte_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [1:0]         action      = sstfb_pkg::ACT_TIME;
    logic signed [63:0] time_us     = '0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic               cfg_data    = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [7:0]         out_byte;
    logic               frame_start;
    logic               frame_stop;
    logic               last;

    display_request_t request_queue[$];
    frame_byte_t      expected_bytes[$];
    logic             flip_shadow  = 1'b0;
    int               error_count  = 0;
    int               holds_asked  = 0;
    int               holds_served = 0;
    int               hold_left    = 0;
    int               burst_left   = 0;
    int               gap_left     = 0;
    int               pattern_left = 0;
    logic [15:0]      ready_pattern = '1;

    seven_segment_time_frame_builder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .time_us    (time_us),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_start(frame_start),
        .frame_stop (frame_stop),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic expect_byte(input logic [7:0] b, input logic st, input logic sp,
                               input logic ls);
        frame_byte_t e;
        e.b  = b;
        e.st = st;
        e.sp = sp;
        e.ls = ls;
        expected_bytes.push_back(e);
    endtask

    // Upside-down image of one digit: a<->d, b<->e, c<->f, g and colon kept.
    function automatic logic [7:0] turn_segments(input logic [7:0] s);
        return {s[7], s[6], s[2], s[1], s[0], s[5], s[4], s[3]};
    endfunction

    task automatic predict_frames(input logic [1:0] act, input logic signed [63:0] t,
                                  input logic flip);
        longint     cs;
        longint     sec;
        longint     frac;
        logic [7:0] d[4];
        logic [7:0] o[4];
        if (act == sstfb_pkg::ACT_BLANK)
        begin
            expect_byte(sstfb_pkg::CMD_BLANK, 1'b1, 1'b1, 1'b1);
        end
        else if (act == sstfb_pkg::ACT_TIME || act == sstfb_pkg::ACT_ZEROS)
        begin
            cs = 0;
            if (act == sstfb_pkg::ACT_TIME && t >= 0)
                cs = t / US_PER_CS;
            if (cs > longint'(sstfb_pkg::CS_MAX))
                cs = longint'(sstfb_pkg::CS_MAX);
            sec  = cs / 100;
            frac = cs % 100;
            if (sec > longint'(sstfb_pkg::SEC_MAX))
                sec = longint'(sstfb_pkg::SEC_MAX);
            d[0] = DIGIT_SEGS[(sec / 10) * 8 +: 8];
            d[1] = DIGIT_SEGS[(sec % 10) * 8 +: 8] | sstfb_pkg::COLON_BIT;
            d[2] = DIGIT_SEGS[(frac / 10) * 8 +: 8];
            d[3] = DIGIT_SEGS[(frac % 10) * 8 +: 8];
            if (flip)
            begin
                // The colon moves with its digit to the third position from the left.
                o[0] = turn_segments(d[3]);
                o[1] = turn_segments(d[2]);
                o[2] = turn_segments(d[1] & ~sstfb_pkg::COLON_BIT)
                       | (d[1] & sstfb_pkg::COLON_BIT);
                o[3] = turn_segments(d[0]);
            end
            else
            begin
                o = d;
            end
            expect_byte(sstfb_pkg::CMD_DATA_AUTO, 1'b1, 1'b1, 1'b0);
            expect_byte(sstfb_pkg::CMD_ADDR0, 1'b1, 1'b0, 1'b0);
            expect_byte(o[0], 1'b0, 1'b0, 1'b0);
            expect_byte(o[1], 1'b0, 1'b0, 1'b0);
            expect_byte(o[2], 1'b0, 1'b0, 1'b0);
            expect_byte(o[3], 1'b0, 1'b1, 1'b0);
            expect_byte(sstfb_pkg::CMD_DISPLAY, 1'b1, 1'b1, 1'b1);
        end
    endtask

    task automatic queue_request(input logic [1:0] act, input logic signed [63:0] t);
        display_request_t r;
        r.act = act;
        r.t   = t;
        request_queue.push_back(r);
    endtask

    // Returns at a falling edge so that the caller can queue items safely.
    task automatic write_flip(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        flip_shadow = v;
        @(negedge clk);
    endtask

    // Waits until all requests are taken and all their bytes have come out,
    // then lets the pipeline settle in case the last request was dropped.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= sstfb_pkg::ACT_TIME;
            time_us    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0 || request_queue.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                action   <= request_queue[0].act;
                time_us  <= request_queue[0].t;
                void'(request_queue.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Output stall pattern, with a long hold-off whenever one is asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            ready_pattern <= '1;
            pattern_left  <= 0;
            hold_left     <= 0;
            holds_served  <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            out_ready    <= 1'b0;
            hold_left    <= LONG_HOLD - 1;
            holds_served <= holds_served + 1;
        end
        else
        begin
            out_ready <= ready_pattern[0];
            if (pattern_left == 0)
            begin
                ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                              : (16'($urandom) | 16'h0001);
                pattern_left  <= $urandom_range(16, 160);
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                pattern_left  <= pattern_left - 1;
            end
        end
    end

    // Predicts on each accepted request and checks each output transaction.
    always @(posedge clk)
    begin : monitor
        frame_byte_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_frames(action, time_us, flip_shadow);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output byte %02h", out_byte));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.b)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.b));
                    if (frame_start !== want.st)
                        report_mismatch($sformatf("frame_start %b, expected %b on byte %02h",
                                                  frame_start, want.st, want.b));
                    if (frame_stop !== want.sp)
                        report_mismatch($sformatf("frame_stop %b, expected %b on byte %02h",
                                                  frame_stop, want.sp, want.b));
                    if (last !== want.ls)
                        report_mismatch($sformatf("last %b, expected %b on byte %02h",
                                                  last, want.ls, want.b));
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int                 f;
        int                 phase;
        int                 n;
        int                 pick;
        logic [1:0]         act;
        logic signed [63:0] t;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests, once without and once with the flip.
        for (f = 0; f < 2; f++)
        begin
            write_flip(f[0]);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd0);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd9999);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd10000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd990000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd1000000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd12340000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd56780000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd90120000);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd999999999);
            queue_request(sstfb_pkg::ACT_TIME, 64'sd9999990000);
            queue_request(sstfb_pkg::ACT_TIME, sstfb_pkg::SAT_US);
            queue_request(sstfb_pkg::ACT_TIME, 64'h7FFF_FFFF_FFFF_FFFF);
            queue_request(sstfb_pkg::ACT_TIME, -64'sd1);
            queue_request(sstfb_pkg::ACT_TIME, -64'sd10000);
            queue_request(sstfb_pkg::ACT_TIME, 64'h8000_0000_0000_0000);
            queue_request(sstfb_pkg::ACT_ZEROS, 64'sd123456789);
            queue_request(sstfb_pkg::ACT_BLANK, -64'sd1);
            queue_request(ACT_UNUSED, 64'sd56780000);
            wait_idle();
        end

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            write_flip((phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 19);
                act  = (pick < 12) ? sstfb_pkg::ACT_TIME :
                       (pick < 15) ? sstfb_pkg::ACT_ZEROS :
                       (pick < 18) ? sstfb_pkg::ACT_BLANK : ACT_UNUSED;
                case ($urandom_range(0, 5))
                    0: t = {$urandom, $urandom};
                    1: t = longint'($urandom_range(0, 99999999));
                    2: t = longint'($urandom) * longint'($urandom_range(1, 8));
                    3: t = sstfb_pkg::SAT_US - 64'sd20000 + longint'($urandom_range(0, 40000));
                    4: t = -longint'($urandom_range(1, 1000000));
                    default:
                        t = longint'($urandom_range(0, 9999)) * US_PER_CS
                            + longint'($urandom_range(0, 2)) - 1;
                endcase
                queue_request(act, t);
            end
            // The output side holds off while requests keep coming, so the
            // block fills up and must stall its input.
            if (phase == 3)
                holds_asked++;
            wait_idle();
        end

        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
